// ----- src/frt_pkg.sv -----
// Shared types and constants for the fragment reassembly tracker.
`timescale 1ns / 1ps
`default_nettype none

package frt_pkg;

    localparam int unsigned FRT_SESSIONS     = 4;
    localparam int unsigned FRT_MAX_FRAGS    = 8;
    localparam int unsigned FRT_PAYLOAD_MAX  = 240;
    localparam int unsigned FRT_HEADER_BYTES = 4;

    localparam logic [31:0] FRT_TIMEOUT_RESET = 32'd5000;

    typedef enum logic [1:0] {
        STATUS_REJECT   = 2'd0,
        STATUS_STORED   = 2'd1,
        STATUS_COMPLETE = 2'd2,
        STATUS_SWEEP    = 2'd3
    } frt_status_t;

    typedef enum logic {
        REQ_FRAGMENT = 1'b0,
        REQ_SWEEP    = 1'b1
    } frt_req_t;

    typedef struct packed {
        logic        req_type;
        logic [31:0] now_ms;
        logic [47:0] src_mac;
        logic [15:0] frag_id;
        logic [7:0]  frag_index;
        logic [7:0]  frag_total;
        logic [7:0]  frame_len;
    } frt_in_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  slot;
        logic [7:0]  chunk_len;
        logic        evicted;
        logic [10:0] total_len;
        logic [4:0]  expired_count;
    } frt_out_t;

    // Controller to datapath commands
    typedef struct packed {
        logic        load;
        logic        scan;
        logic        commit;
        logic        sum;
        logic        result;
        frt_status_t res_kind;
    } frt_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic bad;
        logic sweep;
        logic scan_last;
        logic full;
        logic sum_done;
    } frt_stat_t;

endpackage

`default_nettype wire

// ----- src/frt_ctrl.sv -----
// Sequencing state machine for the fragment reassembly tracker.
`timescale 1ns / 1ps
`default_nettype none

module frt_ctrl
    import frt_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire frt_stat_t stat,
    output frt_cmd_t       cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT,
        S_SUM,
        S_RESULT
    } state_t;

    state_t      state_reg, state_next;
    frt_status_t kind_reg, kind_next;
    logic        out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next      = state_reg;
        kind_next       = kind_reg;
        cmd             = '0;
        cmd.res_kind    = kind_reg;
        out_valid_next  = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.bad && !stat.sweep)
                begin
                    kind_next  = STATUS_REJECT;
                    state_next = S_RESULT;
                end
                else
                begin
                    cmd.scan = 1'b1;
                    if (stat.scan_last)
                    begin
                        if (stat.sweep)
                        begin
                            kind_next  = STATUS_SWEEP;
                            state_next = S_RESULT;
                        end
                        else
                        begin
                            state_next = S_COMMIT;
                        end
                    end
                end
            end
            S_COMMIT:
            begin
                cmd.commit = 1'b1;
                if (stat.full)
                begin
                    state_next = S_SUM;
                end
                else
                begin
                    kind_next  = STATUS_STORED;
                    state_next = S_RESULT;
                end
            end
            S_SUM:
            begin
                cmd.sum = 1'b1;
                if (stat.sum_done)
                begin
                    kind_next  = STATUS_COMPLETE;
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.result     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            kind_reg      <= STATUS_REJECT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/frt_datapath.sv -----
// Session table, fragment length memory and result register.
`timescale 1ns / 1ps
`default_nettype none

module frt_datapath
    import frt_pkg::*;
#(
    parameter int unsigned SESSIONS     = FRT_SESSIONS,
    parameter int unsigned MAX_FRAGS    = FRT_MAX_FRAGS,
    parameter int unsigned PAYLOAD_MAX  = FRT_PAYLOAD_MAX,
    parameter int unsigned HEADER_BYTES = FRT_HEADER_BYTES
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire frt_in_t     in_data,
    input  wire logic        cfg_we,
    input  wire logic [31:0] cfg_data,
    input  wire frt_cmd_t    cmd,
    output frt_stat_t        stat,
    output frt_out_t         out_data
);

    localparam int unsigned SW    = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
    localparam int unsigned DEPTH = SESSIONS * MAX_FRAGS;
    localparam int unsigned LW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned KW    = $clog2(MAX_FRAGS + 1);

    // session table
    logic [SESSIONS-1:0]  active_reg;
    logic [47:0]          mac_reg   [SESSIONS];
    logic [15:0]          pid_reg   [SESSIONS];
    logic [31:0]          start_reg [SESSIONS];
    logic [MAX_FRAGS-1:0] mask_reg  [SESSIONS];
    logic [7:0]           len_mem   [DEPTH];

    logic [31:0] timeout_reg;
    frt_in_t     item_reg;

    // scan results
    logic [SW-1:0]        scan_idx_reg;
    logic                 found_reg;
    logic [SW-1:0]        hit_slot_reg;
    logic [MAX_FRAGS-1:0] mask_cap_reg;
    logic                 free_found_reg;
    logic [SW-1:0]        free_slot_reg;
    logic [31:0]          min_start_reg;
    logic [SW-1:0]        min_slot_reg;
    logic [4:0]           exp_cnt_reg;

    // commit and summing
    logic [SW-1:0] slot_reg;
    logic          evict_reg;
    logic [7:0]    chunk_reg;
    logic [KW-1:0] k_reg;
    logic          pend_reg;
    logic [7:0]    rd_data_reg;
    logic [10:0]   acc_reg;
    frt_out_t      out_reg;

    logic                 cur_act;
    logic                 cur_hit;
    logic                 cur_expired;
    logic [31:0]          cur_age;
    logic [SW-1:0]        sel_slot;
    logic [MAX_FRAGS-1:0] mask_base;
    logic [MAX_FRAGS-1:0] new_mask;
    logic [MAX_FRAGS-1:0] full_pat;
    logic [7:0]           chunk_raw;
    logic [7:0]           chunk_c;
    logic [LW-1:0]        wr_addr;
    logic [LW-1:0]        rd_addr;
    logic                 k_at_total;

    always_comb
    begin
        cur_act     = active_reg[scan_idx_reg];
        cur_hit     = cur_act && (pid_reg[scan_idx_reg] == item_reg.frag_id)
                      && (mac_reg[scan_idx_reg] == item_reg.src_mac);
        cur_age     = item_reg.now_ms - start_reg[scan_idx_reg];
        cur_expired = cur_act && (cur_age > timeout_reg);

        if (found_reg)
        begin
            sel_slot = hit_slot_reg;
        end
        else if (free_found_reg)
        begin
            sel_slot = free_slot_reg;
        end
        else
        begin
            sel_slot = min_slot_reg;
        end

        mask_base = found_reg ? mask_cap_reg : '0;
        for (int j = 0; j < MAX_FRAGS; j++)
        begin
            new_mask[j] = mask_base[j] || (item_reg.frag_index == 8'(j));
            full_pat[j] = (8'(j) < item_reg.frag_total);
        end

        chunk_raw = item_reg.frame_len - 8'(HEADER_BYTES);
        chunk_c   = (chunk_raw > 8'(PAYLOAD_MAX)) ? 8'(PAYLOAD_MAX) : chunk_raw;

        wr_addr = LW'(sel_slot) * LW'(MAX_FRAGS) + LW'(item_reg.frag_index);
        rd_addr = LW'(slot_reg) * LW'(MAX_FRAGS) + LW'(k_reg);

        k_at_total = (k_reg == KW'(item_reg.frag_total));

        stat.sweep     = (item_reg.req_type == REQ_SWEEP);
        stat.bad       = (item_reg.frame_len < 8'(HEADER_BYTES))
                         || (item_reg.frag_total == 8'd0)
                         || (item_reg.frag_total > 8'(MAX_FRAGS))
                         || (item_reg.frag_index >= item_reg.frag_total);
        stat.scan_last = (scan_idx_reg == SW'(SESSIONS - 1));
        stat.full      = (new_mask == full_pat);
        stat.sum_done  = k_at_total && !pend_reg;
    end

    // control-side registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= '0;
            timeout_reg    <= FRT_TIMEOUT_RESET;
            scan_idx_reg   <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            exp_cnt_reg    <= '0;
            k_reg          <= '0;
            pend_reg       <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                timeout_reg <= cfg_data;
            end
            if (cmd.load)
            begin
                scan_idx_reg   <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
                exp_cnt_reg    <= '0;
                k_reg          <= '0;
                pend_reg       <= 1'b0;
                acc_reg        <= '0;
            end
            if (cmd.scan)
            begin
                if (!stat.scan_last)
                begin
                    scan_idx_reg <= scan_idx_reg + SW'(1);
                end
                if (stat.sweep)
                begin
                    // drop stale sessions as the scan passes them
                    if (cur_expired)
                    begin
                        active_reg[scan_idx_reg] <= 1'b0;
                        exp_cnt_reg              <= exp_cnt_reg + 5'd1;
                    end
                end
                else
                begin
                    if (cur_hit && !found_reg)
                    begin
                        found_reg <= 1'b1;
                    end
                    if (!cur_act && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1;
                    end
                end
            end
            if (cmd.commit)
            begin
                active_reg[sel_slot] <= 1'b1;
            end
            if (cmd.sum)
            begin
                if (!k_at_total)
                begin
                    k_reg    <= k_reg + KW'(1);
                    pend_reg <= 1'b1;
                end
                else
                begin
                    pend_reg <= 1'b0;
                end
                if (pend_reg)
                begin
                    acc_reg <= acc_reg + 11'(rd_data_reg);
                end
            end
            if (cmd.result && (cmd.res_kind == STATUS_COMPLETE))
            begin
                active_reg[slot_reg] <= 1'b0;
            end
        end
    end

    // payload registers and table contents
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
        if (cmd.scan && !stat.sweep)
        begin
            if (cur_hit && !found_reg)
            begin
                hit_slot_reg <= scan_idx_reg;
                mask_cap_reg <= mask_reg[scan_idx_reg];
            end
            if (!cur_act && !free_found_reg)
            begin
                free_slot_reg <= scan_idx_reg;
            end
            // strict compare keeps the lowest slot on a tie
            if ((scan_idx_reg == '0) || (start_reg[scan_idx_reg] < min_start_reg))
            begin
                min_start_reg <= start_reg[scan_idx_reg];
                min_slot_reg  <= scan_idx_reg;
            end
        end
        if (cmd.commit)
        begin
            if (!found_reg)
            begin
                mac_reg[sel_slot]   <= item_reg.src_mac;
                pid_reg[sel_slot]   <= item_reg.frag_id;
                start_reg[sel_slot] <= item_reg.now_ms;
            end
            mask_reg[sel_slot] <= new_mask;
            slot_reg           <= sel_slot;
            evict_reg          <= !found_reg && !free_found_reg;
            chunk_reg          <= chunk_c;
        end
        if (cmd.result)
        begin
            case (cmd.res_kind)
                STATUS_STORED, STATUS_COMPLETE:
                begin
                    out_reg.status        <= cmd.res_kind;
                    out_reg.slot          <= 4'(slot_reg);
                    out_reg.chunk_len     <= chunk_reg;
                    out_reg.evicted       <= evict_reg;
                    out_reg.total_len     <= (cmd.res_kind == STATUS_COMPLETE) ? acc_reg
                                                                               : 11'd0;
                    out_reg.expired_count <= '0;
                end
                STATUS_SWEEP:
                begin
                    out_reg.status        <= cmd.res_kind;
                    out_reg.slot          <= '0;
                    out_reg.chunk_len     <= '0;
                    out_reg.evicted       <= 1'b0;
                    out_reg.total_len     <= '0;
                    out_reg.expired_count <= exp_cnt_reg;
                end
                default:
                begin
                    out_reg.status        <= cmd.res_kind;
                    out_reg.slot          <= '0;
                    out_reg.chunk_len     <= '0;
                    out_reg.evicted       <= 1'b0;
                    out_reg.total_len     <= '0;
                    out_reg.expired_count <= '0;
                end
            endcase
        end
    end

    // fragment length memory: written on commit, read one entry per cycle while summing
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            len_mem[wr_addr] <= chunk_c;
        end
        if (cmd.sum && !k_at_total)
        begin
            rd_data_reg <= len_mem[rd_addr];
        end
    end

    assign out_data = out_reg;

endmodule

`default_nettype wire

// ----- src/fragment_reassembly_tracker_unit.sv -----
// A reject skips the session scan, a sweep scans every session, a stored fragment
// is scanned and committed, and a completed packet is scanned, committed and summed
// over its fragment lengths. One item at a time: the next transaction is taken in
// the cycle after the result is registered, even while that result waits in the
// output register. The scan reads one slot and the length memory one entry per cycle.
// Asynchronous active-low reset clears all sessions and sets timeout_ms to 5000.
`timescale 1ns / 1ps
`default_nettype none

module fragment_reassembly_tracker_unit
    import frt_pkg::*;
#(
    parameter int unsigned SESSIONS     = FRT_SESSIONS,
    parameter int unsigned MAX_FRAGS    = FRT_MAX_FRAGS,
    parameter int unsigned PAYLOAD_MAX  = FRT_PAYLOAD_MAX,
    parameter int unsigned HEADER_BYTES = FRT_HEADER_BYTES
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire frt_in_t     in_data,
    output logic             out_valid,
    input  wire logic        out_ready,
    output frt_out_t         out_data,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [31:0] cfg_data
);

    frt_cmd_t  cmd;
    frt_stat_t stat;

    assign cfg_ready = 1'b1;

    frt_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    frt_datapath #(
        .SESSIONS     (SESSIONS),
        .MAX_FRAGS    (MAX_FRAGS),
        .PAYLOAD_MAX  (PAYLOAD_MAX),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_datapath
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (out_data)
    );

endmodule

`default_nettype wire
